>>> src/lpd_pkg.sv
package lpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int KEYLEN_W  = 16;
    localparam int DATALEN_W = 32;
    localparam int HCOUNT_W  = 3;
    localparam int PHASE_W   = 2;
    localparam int PART_W    = 2;
    localparam int TDATA_W   = 56;
    localparam int TUSER_W   = 3;

    localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_KEYWORD = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DATA    = 2'd2;

    localparam logic [PART_W-1:0] PART_KEYWORD = 2'd0;
    localparam logic [PART_W-1:0] PART_DATA    = 2'd1;
    localparam logic [PART_W-1:0] PART_EMPTY   = 2'd2;

    localparam logic [HCOUNT_W-1:0] HDR_KEY_BYTES  = 3'd2;
    localparam logic [HCOUNT_W-1:0] HDR_LAST_COUNT = 3'd5;

    typedef struct packed {
        logic [DATALEN_W-1:0] payload_length;
        logic [KEYLEN_W-1:0]  key_length;
        logic [BYTE_W-1:0]    out_byte;
    } out_data_t;

    typedef struct packed {
        logic                end_of_keyword;
        logic [PART_W-1:0]   part;
    } out_user_t;

endpackage

>>> src/length_prefixed_deframer_top.sv
// Deframer for a byte stream of back-to-back length-prefixed messages.
// Each message opens with a six-byte big-endian header: a 16-bit keyword
// length and then a 32-bit data length, followed by the keyword bytes and
// the data bytes.
// The slave channel takes one raw byte per item. The master channel gives
// one item for each keyword or data byte, tagged with its part, the end of
// keyword mark in tuser and the end of message mark on tlast, together with
// the lengths from the message's header. Header bytes give no item, except
// that a message with both lengths zero gives one empty-message item on its
// last header byte.
// A result is registered at the edge that accepts its byte and is offered
// from the next cycle. Throughput is one byte per cycle while the receiver
// takes items, set by the single result register, which is refilled in the
// same cycle in which it is drained.
// When the receiver stalls the result register holds and s_tready falls
// until the result is taken. Reset clears the parser to the start of a
// header and empties the result register.
module length_prefixed_deframer_top
    import lpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // in_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_byte, key_length, payload_length
    output logic [TUSER_W-1:0] m_tuser,   // part, end_of_keyword
    output logic               m_tlast    // end_of_message
);

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [HCOUNT_W-1:0]  hcount_reg, hcount_next;
    logic [KEYLEN_W-1:0]  keylen_reg, keylen_next;
    logic [DATALEN_W-1:0] datalen_reg, datalen_next;
    logic [DATALEN_W-1:0] remaining_reg, remaining_next;

    logic                 valid_reg;
    out_data_t            data_reg, data_next;
    out_user_t            user_reg, user_next;
    logic                 last_reg, last_next;
    logic                 emit;
    logic                 accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        logic part_last;
        part_last      = (remaining_reg <= {{(DATALEN_W-1){1'b0}}, 1'b1});
        phase_next     = phase_reg;
        hcount_next    = hcount_reg;
        keylen_next    = keylen_reg;
        datalen_next   = datalen_reg;
        remaining_next = remaining_reg;
        emit           = 1'b0;
        data_next.out_byte       = s_tdata;
        data_next.key_length     = keylen_reg;
        data_next.payload_length = datalen_reg;
        user_next.part           = PART_KEYWORD;
        user_next.end_of_keyword = 1'b0;
        last_next                = 1'b0;

        unique case (phase_reg)
            PH_KEYWORD:
            begin
                emit                     = 1'b1;
                user_next.end_of_keyword = part_last;
                last_next                = part_last && (datalen_reg == '0);
                remaining_next           = part_last ? '0 : remaining_reg - 1'b1;
                if (part_last)
                begin
                    if (datalen_reg != '0)
                    begin
                        phase_next     = PH_DATA;
                        remaining_next = datalen_reg;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            PH_DATA:
            begin
                emit           = 1'b1;
                user_next.part = PART_DATA;
                last_next      = part_last;
                remaining_next = part_last ? '0 : remaining_reg - 1'b1;
                if (part_last)
                begin
                    phase_next = PH_HEADER;
                end
            end
            default:
            begin
                // The unused phase code is handled as the header phase.
                phase_next = PH_HEADER;
                if (hcount_reg < HDR_KEY_BYTES)
                begin
                    keylen_next = {keylen_reg[KEYLEN_W-BYTE_W-1:0], s_tdata};
                    hcount_next = hcount_reg + 1'b1;
                end
                else
                begin
                    datalen_next = {datalen_reg[DATALEN_W-BYTE_W-1:0], s_tdata};
                    if (hcount_reg < HDR_LAST_COUNT)
                    begin
                        hcount_next = hcount_reg + 1'b1;
                    end
                    else
                    begin
                        hcount_next = '0;
                        if (keylen_reg != '0)
                        begin
                            phase_next     = PH_KEYWORD;
                            remaining_next = {{(DATALEN_W-KEYLEN_W){1'b0}}, keylen_reg};
                        end
                        else if (datalen_next != '0)
                        begin
                            phase_next     = PH_DATA;
                            remaining_next = datalen_next;
                        end
                        else
                        begin
                            emit                     = 1'b1;
                            data_next.out_byte       = '0;
                            data_next.payload_length = datalen_next;
                            user_next.part           = PART_EMPTY;
                            last_next                = 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hcount_reg    <= '0;
            keylen_reg    <= '0;
            datalen_reg   <= '0;
            remaining_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                hcount_reg    <= hcount_next;
                keylen_reg    <= keylen_next;
                datalen_reg   <= datalen_next;
                remaining_reg <= remaining_next;
                valid_reg     <= emit;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        hcount_reg <= HDR_LAST_COUNT)
        else $error("Header byte count has run past the header.");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_KEYWORD || phase_reg == PH_DATA) |=> m_tvalid)
        else $error("A keyword or data byte gave no item.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && user_reg.part == PART_EMPTY |->
            last_reg && data_reg.key_length == '0 && data_reg.payload_length == '0)
        else $error("Empty-message item carries a length or lacks its end mark.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && user_reg.end_of_keyword |-> user_reg.part == PART_KEYWORD)
        else $error("End of keyword mark on an item that is not a keyword byte.");

endmodule
